### rtl/core/radio_audio_packet_deframer_core_assert.svh
// Assertion macros shared by the deframer RTL.
`ifndef RADIO_AUDIO_PACKET_DEFRAMER_CORE_ASSERT_SVH
`define RADIO_AUDIO_PACKET_DEFRAMER_CORE_ASSERT_SVH

// The property must hold at every clock edge outside reset.
`define RAPD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define RAPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/rapd_pkg.sv
// Shared types and constants of the radio audio packet deframer.
package rapd_pkg;

    localparam int unsigned GROUPS_PER_PACKET = 6;
    localparam int unsigned BYTES_PER_GROUP   = 5;
    localparam int unsigned DATA_BYTES        = GROUPS_PER_PACKET * BYTES_PER_GROUP;
    localparam int unsigned AUX_POSITION      = DATA_BYTES + 1;
    localparam int unsigned POS_W             = $clog2(AUX_POSITION + 1);

    localparam logic [POS_W-1:0] POS_IDLE  = '0;
    localparam logic [POS_W-1:0] POS_FIRST = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LAST_DATA = POS_W'(DATA_BYTES);
    localparam logic [POS_W-1:0] POS_AUX   = POS_W'(AUX_POSITION);

    // Offset of the last byte within its five-byte group.
    localparam logic [2:0] OFF_LAST = 3'(BYTES_PER_GROUP - 1);

    localparam logic [7:0] HI_NIBBLE_MASK = 8'hf0;
    localparam logic [7:0] LO_NIBBLE_MASK = 8'h0f;
    localparam logic [7:0] ROUTE_MASK     = 8'h07;

    typedef enum logic [2:0] {
        KIND_SAMPLE   = 3'd0,
        KIND_LOST     = 3'd1,
        KIND_SWITCHES = 3'd2,
        KIND_BATTERY  = 3'd3,
        KIND_POT      = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ROUTE_NONE0    = 3'd0,
        ROUTE_SWITCHES = 3'd1,
        ROUTE_BATTERY  = 3'd2,
        ROUTE_POT0     = 3'd3,
        ROUTE_POT1     = 3'd4,
        ROUTE_POT2     = 3'd5,
        ROUTE_NONE6    = 3'd6,
        ROUTE_NONE7    = 3'd7
    } route_t;

    // One result as held in the output queue; the sample keeps only its
    // 20 significant bits.
    typedef struct packed {
        kind_t       kind;
        logic [19:0] sample;
        logic [7:0]  aux;
        logic [1:0]  pot;
        logic        last;
    } result_t;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

### rtl/core/radio_audio_packet_deframer_core.sv
// Radio audio packet deframer: byte parser with a small result queue.
//
// The block takes one payload byte per cycle while s_ready is high. A
// header byte checks the packet number for continuity, the bytes of each
// five-byte group are held until the fifth arrives, and that byte yields
// two 20-bit samples; the trailing auxiliary byte is routed by the header's
// low three bits. Parsing is done in the accepting cycle and its results go
// into a four-entry result queue, which hands out one result per cycle
// while m_ready is high. s_ready is high while the queue holds two or fewer
// results, so bytes flow at one per cycle as long as the result side keeps
// taking one result per cycle. Results are registered in the queue before
// they show on the m_ ports. There is no clearing period after reset.
`include "radio_audio_packet_deframer_core_assert.svh"

module radio_audio_packet_deframer_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    input  logic               s_packet_start,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_result_kind,
    output logic signed [31:0] m_audio_sample,
    output logic [7:0]         m_aux_value,
    output logic [1:0]         m_pot_index,
    output logic               m_last_of_run
);

    logic [rapd_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [2:0]                  off_reg, off_next;
    logic [7:0]                  prev_num_reg, prev_num_next;
    logic [2:0]                  route_reg, route_next;
    logic [7:0]                  held_reg [4];

    rapd_pkg::result_t           queue_reg [rapd_pkg::QUEUE_DEPTH];
    logic [rapd_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [rapd_pkg::QCNT_W-1:0] cnt_reg, cnt_next;

    logic                        in_acc, out_acc;
    logic [1:0]                  push_n;
    logic                        held_we;
    rapd_pkg::result_t           res0, res1, head;
    logic                        lost;
    logic                        in_data;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;
    assign lost    = (s_rx_byte - prev_num_reg) != 8'd1;
    assign in_data = pos_reg inside {[rapd_pkg::POS_FIRST:rapd_pkg::POS_LAST_DATA]};

    always_comb begin
        pos_next      = pos_reg;
        off_next      = off_reg;
        prev_num_next = prev_num_reg;
        route_next    = route_reg;
        push_n        = 2'd0;
        held_we       = 1'b0;
        res0          = '{kind: rapd_pkg::KIND_SAMPLE, sample: '0, aux: '0, pot: '0,
                          last: 1'b1};
        res1          = '{kind: rapd_pkg::KIND_SAMPLE, sample: '0, aux: '0, pot: '0,
                          last: 1'b1};

        if (in_acc) begin
            if (s_packet_start) begin
                prev_num_next = s_rx_byte;
                route_next    = 3'(s_rx_byte & rapd_pkg::ROUTE_MASK);
                pos_next      = rapd_pkg::POS_FIRST;
                off_next      = 3'd0;
                if (lost) begin
                    res0.kind = rapd_pkg::KIND_LOST;
                    push_n    = 2'd1;
                end
            end else if (pos_reg == rapd_pkg::POS_AUX) begin
                pos_next = rapd_pkg::POS_IDLE;
                res0.aux = s_rx_byte;
                case (rapd_pkg::route_t'(route_reg))
                    rapd_pkg::ROUTE_SWITCHES: begin
                        res0.kind = rapd_pkg::KIND_SWITCHES;
                        push_n    = 2'd1;
                    end
                    rapd_pkg::ROUTE_BATTERY: begin
                        res0.kind = rapd_pkg::KIND_BATTERY;
                        push_n    = 2'd1;
                    end
                    rapd_pkg::ROUTE_POT0: begin
                        res0.kind = rapd_pkg::KIND_POT;
                        res0.pot  = 2'd0;
                        push_n    = 2'd1;
                    end
                    rapd_pkg::ROUTE_POT1: begin
                        res0.kind = rapd_pkg::KIND_POT;
                        res0.pot  = 2'd1;
                        push_n    = 2'd1;
                    end
                    rapd_pkg::ROUTE_POT2: begin
                        res0.kind = rapd_pkg::KIND_POT;
                        res0.pot  = 2'd2;
                        push_n    = 2'd1;
                    end
                    default: begin
                        push_n = 2'd0;
                    end
                endcase
            end else if (in_data) begin
                pos_next = pos_reg + rapd_pkg::POS_FIRST;
                if (off_reg == rapd_pkg::OFF_LAST) begin
                    // Fifth byte: high nibble finishes sample one, low nibble sample two.
                    off_next    = 3'd0;
                    res0.sample = {held_reg[0], held_reg[1],
                                   4'((s_rx_byte & rapd_pkg::HI_NIBBLE_MASK) >> 4)};
                    res0.last   = 1'b0;
                    res1.sample = {held_reg[2], held_reg[3],
                                   4'(s_rx_byte & rapd_pkg::LO_NIBBLE_MASK)};
                    push_n      = 2'd2;
                end else begin
                    off_next = off_reg + 3'd1;
                    held_we  = 1'b1;
                end
            end
        end
    end

    assign cnt_next = cnt_reg + rapd_pkg::QCNT_W'(push_n)
                    - (out_acc ? rapd_pkg::QCNT_W'(1) : rapd_pkg::QCNT_W'(0));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= rapd_pkg::POS_IDLE;
            off_reg      <= 3'd0;
            prev_num_reg <= 8'd0;
            route_reg    <= 3'd0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
        end else begin
            pos_reg      <= pos_next;
            off_reg      <= off_next;
            prev_num_reg <= prev_num_next;
            route_reg    <= route_next;
            cnt_reg      <= cnt_next;
            wr_ptr_reg   <= wr_ptr_reg + rapd_pkg::QPTR_W'(push_n);
            if (out_acc) begin
                rd_ptr_reg <= rd_ptr_reg + rapd_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (held_we) begin
            held_reg[off_reg[1:0]] <= s_rx_byte;
        end
        if (push_n != 2'd0) begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (push_n == 2'd2) begin
            queue_reg[wr_ptr_reg + rapd_pkg::QPTR_W'(1)] <= res1;
        end
    end

    // Room for the two results that the worst byte can cause.
    assign s_ready = cnt_reg <= rapd_pkg::QCNT_W'(rapd_pkg::QUEUE_DEPTH - 2);

    assign head           = queue_reg[rd_ptr_reg];
    assign m_valid        = cnt_reg != '0;
    assign m_result_kind  = head.kind;
    assign m_audio_sample = {head.sample, 12'd0};
    assign m_aux_value    = head.aux;
    assign m_pot_index    = head.pot;
    assign m_last_of_run  = head.last;

    `RAPD_ASSERT_ALWAYS(a_cnt_bound,
        cnt_reg <= rapd_pkg::QCNT_W'(rapd_pkg::QUEUE_DEPTH), "result queue overflow")
    `RAPD_ASSERT_ALWAYS(a_pos_bound, pos_reg <= rapd_pkg::POS_AUX, "byte position out of range")
    `RAPD_ASSERT_NEXT(a_lost_push, in_acc && s_packet_start && lost && !out_acc,
        cnt_reg == $past(cnt_reg) + rapd_pkg::QCNT_W'(1), "lost packet request not queued")
    `RAPD_ASSERT_NEXT(a_pair, out_acc && head.kind == rapd_pkg::KIND_SAMPLE && !head.last,
        m_valid && head.kind == rapd_pkg::KIND_SAMPLE && head.last,
        "second sample of a pair missing")

endmodule
